// ===== rtl/core/dts_pkg.sv =====
// shared types and constants of the dual thermostat with spike filter
package dts_pkg;

  localparam int TEMP_W   = 11;          // temperature width, 1/16 degree units
  localparam int CMP_W    = TEMP_W + 2;  // signed compare width, room for target*16 +/- band
  localparam int HTGT_W   = 6;
  localparam int CTGT_W   = 5;
  localparam int SPIKE_W  = 11;
  localparam int BAND_W   = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ_OK   = 2'd0,
    CMD_READ_FAIL = 2'd1,
    CMD_START     = 2'd2,
    CMD_STOP      = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAT_TARGET = 2'd0,
    CFG_COOL_TARGET = 2'd1,
    CFG_SPIKE_LIMIT = 2'd2,
    CFG_BAND        = 2'd3
  } cfg_idx_t;

  localparam logic SIDE_HEAT = 1'b0;
  localparam logic SIDE_COOL = 1'b1;

  localparam logic [HTGT_W-1:0]  HEAT_TARGET_RST = HTGT_W'(25);
  localparam logic [CTGT_W-1:0]  COOL_TARGET_RST = CTGT_W'(10);
  localparam logic [SPIKE_W-1:0] SPIKE_LIMIT_RST = SPIKE_W'(160);
  localparam logic [BAND_W-1:0]  BAND_RST        = BAND_W'(32);
  localparam logic [TEMP_W-1:0]  HEAT_LAST_RST   = TEMP_W'(400);
  localparam logic [TEMP_W-1:0]  COOL_LAST_RST   = TEMP_W'(160);

  typedef struct packed {
    logic              heater_on;
    logic              cooler_on;
    logic              heat_running;
    logic              cool_running;
    logic              heat_start_allowed;
    logic              cool_start_allowed;
    logic [TEMP_W-1:0] heat_temp;
    logic [TEMP_W-1:0] cool_temp;
    logic              heat_temp_valid;
    logic              cool_temp_valid;
    logic              start_refused;
  } res_t;

endpackage

// ===== rtl/core/dts_if.sv =====
// event and result channel interfaces of the dual thermostat
interface dts_in_if import dts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic              side;
  logic [TEMP_W-1:0] reading;

  modport source (output valid, cmd, side, reading, input ready);
  modport sink   (input valid, cmd, side, reading, output ready);
endinterface

interface dts_out_if import dts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              heater_on;
  logic              cooler_on;
  logic              heat_running;
  logic              cool_running;
  logic              heat_start_allowed;
  logic              cool_start_allowed;
  logic [TEMP_W-1:0] heat_temp;
  logic [TEMP_W-1:0] cool_temp;
  logic              heat_temp_valid;
  logic              cool_temp_valid;
  logic              start_refused;

  modport source (output valid, heater_on, cooler_on, heat_running, cool_running,
                  heat_start_allowed, cool_start_allowed, heat_temp, cool_temp,
                  heat_temp_valid, cool_temp_valid, start_refused,
                  input ready);
  modport sink   (input valid, heater_on, cooler_on, heat_running, cool_running,
                  heat_start_allowed, cool_start_allowed, heat_temp, cool_temp,
                  heat_temp_valid, cool_temp_valid, start_refused,
                  output ready);
endinterface

// ===== rtl/core/dual_thermostat_spike_filter_top.sv =====
// top level of the two-side on/off thermostat with spike filtered sensors
//
//  channel  | dir | handshake            | beat
//  ---------+-----+----------------------+-------------------------------------
//  in_bus   | in  | valid/ready          | cmd, side, reading
//  out_bus  | out | valid/ready          | drives, enables, start flags, temps
//  cfg_*    | in  | cfg_we, no stall     | cfg_index selects target/limit/band
//
// one beat in, one beat out, the result is registered and shown in the cycle after
// the beat is taken; a new beat is taken every cycle as long as the result register is empty or being drained
// side state is updated at the edge that takes the beat, so back to back
// beats see the previous beat's effect
// in_bus.ready drops only while a result waits and out_bus.ready is low
// rst_n is synchronous: enables, drives and seen flags clear, last temps go
// to 25.0 / 10.0 degrees, registers go to their defaults
module dual_thermostat_spike_filter_top import dts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dts_in_if.sink                in_bus,
  dts_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [HTGT_W-1:0]  heat_target_r;
  logic [CTGT_W-1:0]  cool_target_r;
  logic [SPIKE_W-1:0] spike_limit_r;
  logic [BAND_W-1:0]  band_r;

  // side state
  logic [TEMP_W-1:0] heat_last_r, heat_last_nxt;
  logic [TEMP_W-1:0] cool_last_r, cool_last_nxt;
  logic heat_seen_r, heat_seen_nxt, heat_en_r, heat_en_nxt, heat_drv_r, heat_drv_nxt;
  logic cool_seen_r, cool_seen_nxt, cool_en_r, cool_en_nxt, cool_drv_r, cool_drv_nxt;
  logic heat_run, cool_run, refused;

  // result register
  res_t out_r, out_nxt;
  logic out_valid_r;

  logic in_acc;
  cmd_t cmd;

  // derived values
  logic [TEMP_W-1:0]       heat_diff, cool_diff;
  logic signed [CMP_W-1:0] heat_goal, cool_goal, heat_on_thr, cool_on_thr;
  logic signed [CMP_W-1:0] heat_t_cur, cool_t_cur, heat_t, cool_t;

  assign cmd          = cmd_t'(in_bus.cmd);
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_target_r <= HEAT_TARGET_RST;
      cool_target_r <= COOL_TARGET_RST;
      spike_limit_r <= SPIKE_LIMIT_RST;
      band_r        <= BAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAT_TARGET: heat_target_r <= cfg_data[HTGT_W-1:0];
        CFG_COOL_TARGET: cool_target_r <= cfg_data[CTGT_W-1:0];
        CFG_SPIKE_LIMIT: spike_limit_r <= cfg_data[SPIKE_W-1:0];
        CFG_BAND:        band_r        <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // targets in 1/16 degree and the switch-on thresholds, heat one may go negative
  assign heat_goal   = $signed(CMP_W'({heat_target_r, 4'b0000}));
  assign cool_goal   = $signed(CMP_W'({cool_target_r, 4'b0000}));
  assign heat_on_thr = heat_goal - $signed(CMP_W'(band_r));
  assign cool_on_thr = cool_goal + $signed(CMP_W'(band_r));

  // spike filter distance to the last valid value
  assign heat_diff = (in_bus.reading > heat_last_r) ? in_bus.reading - heat_last_r
                                                    : heat_last_r - in_bus.reading;
  assign cool_diff = (in_bus.reading > cool_last_r) ? in_bus.reading - cool_last_r
                                                    : cool_last_r - in_bus.reading;

  assign heat_t_cur = $signed(CMP_W'(heat_last_r));
  assign cool_t_cur = $signed(CMP_W'(cool_last_r));

  // ---------------------------------------------------------------------------
  // event decode: reading, enable and run flags per side
  // ---------------------------------------------------------------------------
  always_comb begin
    heat_last_nxt = heat_last_r;
    heat_seen_nxt = heat_seen_r;
    heat_en_nxt   = heat_en_r;
    cool_last_nxt = cool_last_r;
    cool_seen_nxt = cool_seen_r;
    cool_en_nxt   = cool_en_r;
    heat_run      = 1'b0;
    cool_run      = 1'b0;
    refused       = 1'b0;
    case (cmd)
      CMD_READ_OK: begin
        if (in_bus.side == SIDE_COOL) begin
          cool_run = 1'b1;
          if (!cool_seen_r || (cool_diff <= spike_limit_r)) begin
            cool_last_nxt = in_bus.reading;
          end
          cool_seen_nxt = 1'b1;
        end else begin
          heat_run = 1'b1;
          if (!heat_seen_r || (heat_diff <= spike_limit_r)) begin
            heat_last_nxt = in_bus.reading;
          end
          heat_seen_nxt = 1'b1;
        end
      end
      CMD_READ_FAIL: begin
        // reuse the last valid value, only once one exists
        if (in_bus.side == SIDE_COOL) cool_run = cool_seen_r;
        else                          heat_run = heat_seen_r;
      end
      CMD_START: begin
        // start while running is a no-op, not a refusal
        if (in_bus.side == SIDE_COOL) begin
          if (!cool_en_r) begin
            if (!cool_seen_r || (cool_goal >= cool_t_cur)) begin
              refused = 1'b1;
            end else begin
              cool_en_nxt = 1'b1;
              cool_run    = 1'b1;
            end
          end
        end else begin
          if (!heat_en_r) begin
            if (!heat_seen_r || (heat_goal <= heat_t_cur)) begin
              refused = 1'b1;
            end else begin
              heat_en_nxt = 1'b1;
              heat_run    = 1'b1;
            end
          end
        end
      end
      CMD_STOP: begin
        if (in_bus.side == SIDE_COOL) cool_en_nxt = 1'b0;
        else                          heat_en_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  assign heat_t = $signed(CMP_W'(heat_last_nxt));
  assign cool_t = $signed(CMP_W'(cool_last_nxt));

  // ---------------------------------------------------------------------------
  // hysteresis control on the updated temperature
  // ---------------------------------------------------------------------------
  always_comb begin
    heat_drv_nxt = heat_drv_r;
    cool_drv_nxt = cool_drv_r;
    if (cmd == CMD_STOP && in_bus.side == SIDE_HEAT) begin
      heat_drv_nxt = 1'b0;
    end else if (heat_run) begin
      if (!heat_en_nxt)             heat_drv_nxt = 1'b0;
      else if (heat_drv_r)          heat_drv_nxt = !(heat_t >= heat_goal);
      else if (heat_t <= heat_on_thr) heat_drv_nxt = 1'b1;
    end
    if (cmd == CMD_STOP && in_bus.side == SIDE_COOL) begin
      cool_drv_nxt = 1'b0;
    end else if (cool_run) begin
      if (!cool_en_nxt)             cool_drv_nxt = 1'b0;
      else if (cool_drv_r)          cool_drv_nxt = !(cool_t <= cool_goal);
      else if (cool_t >= cool_on_thr) cool_drv_nxt = 1'b1;
    end
  end

  // result beat built from the post-event state
  always_comb begin
    out_nxt.heater_on          = heat_drv_nxt;
    out_nxt.cooler_on          = cool_drv_nxt;
    out_nxt.heat_running       = heat_en_nxt;
    out_nxt.cool_running       = cool_en_nxt;
    out_nxt.heat_start_allowed = heat_seen_nxt && !heat_en_nxt && (heat_goal > heat_t);
    out_nxt.cool_start_allowed = cool_seen_nxt && !cool_en_nxt && (cool_goal < cool_t);
    out_nxt.heat_temp          = heat_last_nxt;
    out_nxt.cool_temp          = cool_last_nxt;
    out_nxt.heat_temp_valid    = heat_seen_nxt;
    out_nxt.cool_temp_valid    = cool_seen_nxt;
    out_nxt.start_refused      = refused;
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_last_r <= HEAT_LAST_RST;
      cool_last_r <= COOL_LAST_RST;
      heat_seen_r <= 1'b0;
      heat_en_r   <= 1'b0;
      heat_drv_r  <= 1'b0;
      cool_seen_r <= 1'b0;
      cool_en_r   <= 1'b0;
      cool_drv_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        heat_last_r <= heat_last_nxt;
        cool_last_r <= cool_last_nxt;
        heat_seen_r <= heat_seen_nxt;
        heat_en_r   <= heat_en_nxt;
        heat_drv_r  <= heat_drv_nxt;
        cool_seen_r <= cool_seen_nxt;
        cool_en_r   <= cool_en_nxt;
        cool_drv_r  <= cool_drv_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.heater_on          = out_r.heater_on;
  assign out_bus.cooler_on          = out_r.cooler_on;
  assign out_bus.heat_running       = out_r.heat_running;
  assign out_bus.cool_running       = out_r.cool_running;
  assign out_bus.heat_start_allowed = out_r.heat_start_allowed;
  assign out_bus.cool_start_allowed = out_r.cool_start_allowed;
  assign out_bus.heat_temp          = out_r.heat_temp;
  assign out_bus.cool_temp          = out_r.cool_temp;
  assign out_bus.heat_temp_valid    = out_r.heat_temp_valid;
  assign out_bus.cool_temp_valid    = out_r.cool_temp_valid;
  assign out_bus.start_refused      = out_r.start_refused;

`ifndef NO_ASSERTIONS
  // a drive is never on for a disabled side
  a_heat_drv_en: assert property (@(posedge clk) disable iff (!rst_n)
    heat_drv_r |-> heat_en_r) else $error("heater drive on while heating disabled");

  a_cool_drv_en: assert property (@(posedge clk) disable iff (!rst_n)
    cool_drv_r |-> cool_en_r) else $error("cooler drive on while cooling disabled");

  // a stop on the heating side leaves it disabled and its drive off
  a_heat_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_STOP && in_bus.side == SIDE_HEAT)
      |=> (!heat_en_r && !heat_drv_r && out_valid_r))
    else $error("heating stop not applied");

  // a refused start never changes either enable
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && refused) |=> ($stable(heat_en_r) && $stable(cool_en_r)))
    else $error("refused start changed an enable");
`endif

endmodule
